// ===== rtl/cida_pkg.sv =====
`default_nettype none
package cida_pkg;

   localparam int NOW_W      = 63;
   localparam int TYPE_W     = 32;
   localparam int FID_W      = 10;
   localparam int DL_W       = 64;
   localparam int CAP_W      = 11;
   localparam int TMO_W      = 32;
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam int REQ_NOW_LSB  = 0;
   localparam int REQ_TYPE_LSB = REQ_NOW_LSB + NOW_W;
   localparam int REQ_FID_LSB  = REQ_TYPE_LSB + TYPE_W;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = 1'b1;

   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // shared add / compare unit
   typedef struct packed {
      logic            sub;
      logic [DL_W-1:0] a;
      logic [DL_W-1:0] b;
   } unit_req_type;

   typedef struct packed {
      logic [DL_W-1:0] sum;
      logic            ge;
   } unit_rsp_type;

endpackage
`default_nettype wire

// ===== rtl/cida_unit.sv =====
`default_nettype none
module cida_unit (
   input  wire  cida_pkg::unit_req_type req,
   output cida_pkg::unit_rsp_type       rsp
);
   import cida_pkg::*;

   logic [DL_W:0] op_b;
   logic [DL_W:0] total;

   always_comb begin
      op_b  = {1'b0, (req.sub ? ~req.b : req.b)};
      total = {1'b0, req.a} + op_b + (DL_W + 1)'(req.sub);
      rsp.sum = total[DL_W-1:0];
      // no borrow on a - b means a >= b
      rsp.ge  = req.sub & total[DL_W];
   end

endmodule
`default_nettype wire

// ===== rtl/counter_id_allocator_reuse_delay.sv =====
// Counter id allocator with reuse delay.
// req channel: one item per request. tuser is the mode (0 allocate, 1 free).
// rsp channel: exactly one item per request: granted id, status (1 = full) and
// a clear flag set when a reclaimed id is handed out again.
// csr channel: index 0 counter capacity, index 1 reuse timeout in ms. Always
// ready; write only while no request is in flight.
// Timing: one request at a time, req_tready is low while it is in work.
// A free passes through S_FREE_CHK and then S_OUT. An allocate walks the
// free list from its oldest entry: each entry is read (S_SCAN_RD, S_SCAN_ID)
// and, unless its id is at or above the capacity, its deadline is compared
// (S_SCAN_CMP); at the list end it takes a new id or reports full (S_OUT).
// Taking an entry from the list closes the gap by moving each later entry
// down (S_SHIFT_RD, S_SHIFT_WR).
// A finished item sits in the rsp register; the next request is accepted
// meanwhile and only waits at its end if rsp is still stalled.
// Reset (synchronous): empty free list, high-water mark zero, capacity 1024,
// timeout 0. No clearing pass: the block is ready the cycle after reset.
`default_nettype none
module counter_id_allocator_reuse_delay #(
   parameter int MAX_COUNTERS = 1024
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_tvalid,
   output logic                            req_tready,
   input  wire [cida_pkg::REQ_DATA_W-1:0]  req_tdata,  // now_ms, type_code, free_id, zero pad
   input  wire                             req_tuser,  // mode
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   output logic [cida_pkg::RSP_DATA_W-1:0] rsp_tdata,  // granted_id, status, clear_value, zero pad
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire [cida_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [cida_pkg::CSR_DATA_W-1:0]  csr_data
);
   import cida_pkg::*;

   localparam int ID_W  = $clog2(MAX_COUNTERS);
   localparam int CNT_W = $clog2(MAX_COUNTERS + 1);
   localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   typedef enum logic [2:0] {
      S_IDLE, S_FREE_CHK, S_SCAN_RD, S_SCAN_ID, S_SCAN_CMP, S_SHIFT_RD, S_SHIFT_WR, S_OUT
   } state_type;

   state_type            state_ff;
   logic [CAP_W-1:0]     cap_ff;
   logic [TMO_W-1:0]     tmo_ff;
   logic [NOW_W-1:0]     now_ff;
   logic [TYPE_W-1:0]    type_ff;
   logic [FID_W-1:0]     fid_ff;
   logic [CNT_W-1:0]     idx_ff;
   logic [ID_W-1:0]      id_ff;
   logic [CNT_W-1:0]     free_cnt_ff;
   logic [CNT_W-1:0]     next_id_ff;
   logic [FID_W-1:0]     res_id_ff;
   logic                 res_status_ff;
   logic                 res_clear_ff;
   logic                 rsp_valid_ff;
   logic [FID_W-1:0]     rsp_id_ff;
   logic                 rsp_status_ff;
   logic                 rsp_clear_ff;

   logic                 ab_mem [MAX_COUNTERS];
   logic [DL_W-1:0]      dl_mem [MAX_COUNTERS];
   logic [TYPE_W-1:0]    ty_mem [MAX_COUNTERS];
   logic [ID_W-1:0]      fl_mem [MAX_COUNTERS];
   logic                 ab_rd_ff;
   logic [DL_W-1:0]      dl_rd_ff;
   logic [ID_W-1:0]      fl_rd_ff;

   logic                 req_fire;
   logic [FID_W-1:0]     req_fid;
   logic [ID_W-1:0]      fid_idx;
   logic [CNT_W:0]       idx_nx;
   logic [CW-1:0]        cap_ext;
   logic [CNT_W-1:0]     cap_use;
   logic                 free_ok;
   logic                 list_end;
   logic                 take_new;
   logic                 take_old;
   logic                 skip_id;
   logic                 out_free;

   logic                 ab_we;
   logic                 ab_wbit;
   logic [ID_W-1:0]      ab_waddr;
   logic                 ty_we;
   logic                 dl_we;
   logic                 fl_we;
   logic [ID_W-1:0]      fl_waddr;
   logic [ID_W-1:0]      fl_wdata;
   logic [ID_W-1:0]      fl_raddr;

   unit_req_type         u_req;
   unit_rsp_type         u_rsp;

   cida_unit u_unit (
      .req (u_req),
      .rsp (u_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign req_fid    = req_tdata[REQ_FID_LSB +: FID_W];
   assign fid_idx    = ID_W'(fid_ff);
   assign idx_nx     = {1'b0, idx_ff} + 1'b1;
   assign csr_ready  = 1'b1;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - FID_W - 2)'(0), rsp_clear_ff, rsp_status_ff, rsp_id_ff};

   always_comb begin
      cap_ext = (CW'(cap_ff) < CW'(MAX_COUNTERS)) ? CW'(cap_ff) : CW'(MAX_COUNTERS);
      cap_use = cap_ext[CNT_W-1:0];
      free_ok = ab_rd_ff && (32'(fid_ff) < 32'(next_id_ff))
                && (32'(free_cnt_ff) < 32'(MAX_COUNTERS));
      list_end = (idx_ff >= free_cnt_ff);
      skip_id  = (CNT_W'(fl_rd_ff) >= cap_use);
   end

   always_comb begin
      u_req.sub = (state_ff == S_SCAN_CMP);
      u_req.a   = {1'b0, now_ff};
      u_req.b   = (state_ff == S_SCAN_CMP) ? dl_rd_ff : DL_W'(tmo_ff);
   end

   always_comb begin
      take_new = (state_ff == S_SCAN_RD) && list_end && (next_id_ff < cap_use);
      take_old = (state_ff == S_SCAN_CMP) && u_rsp.ge;
      ab_we    = take_new || take_old || ((state_ff == S_FREE_CHK) && free_ok);
      ab_wbit  = (state_ff != S_FREE_CHK);
      ty_we    = take_new || take_old;
      dl_we    = (state_ff == S_FREE_CHK) && free_ok;
      if (state_ff == S_FREE_CHK) begin
         ab_waddr = fid_idx;
      end else if (take_new) begin
         ab_waddr = next_id_ff[ID_W-1:0];
      end else begin
         ab_waddr = id_ff;
      end
      fl_we    = dl_we || (state_ff == S_SHIFT_WR);
      fl_waddr = (state_ff == S_FREE_CHK) ? free_cnt_ff[ID_W-1:0] : idx_ff[ID_W-1:0];
      fl_wdata = (state_ff == S_FREE_CHK) ? fid_idx : fl_rd_ff;
      fl_raddr = (state_ff == S_SCAN_RD) ? idx_ff[ID_W-1:0] : idx_nx[ID_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ab_we) begin
         ab_mem[ab_waddr] <= ab_wbit;
      end
      ab_rd_ff <= ab_mem[ID_W'(req_fid)];
   end

   always_ff @(posedge clock) begin
      if (ty_we) begin
         ty_mem[ab_waddr] <= type_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (dl_we) begin
         dl_mem[fid_idx] <= u_rsp.sum;
      end
      dl_rd_ff <= dl_mem[fl_rd_ff];
   end

   always_ff @(posedge clock) begin
      if (fl_we) begin
         fl_mem[fl_waddr] <= fl_wdata;
      end
      fl_rd_ff <= fl_mem[fl_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
         tmo_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CAPACITY: cap_ff <= csr_data[CAP_W-1:0];
            CSR_TIMEOUT:  tmo_ff <= csr_data[TMO_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         free_cnt_ff   <= '0;
         next_id_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  now_ff  <= req_tdata[REQ_NOW_LSB +: NOW_W];
                  type_ff <= req_tdata[REQ_TYPE_LSB +: TYPE_W];
                  fid_ff  <= req_fid;
                  idx_ff  <= '0;
                  state_ff <= (req_tuser == MODE_FREE) ? S_FREE_CHK : S_SCAN_RD;
               end
            end
            S_FREE_CHK: begin
               if (free_ok) begin
                  free_cnt_ff <= free_cnt_ff + 1'b1;
               end
               res_id_ff     <= fid_ff;
               res_status_ff <= 1'b0;
               res_clear_ff  <= 1'b0;
               state_ff      <= S_OUT;
            end
            S_SCAN_RD: begin
               if (!list_end) begin
                  state_ff <= S_SCAN_ID;
               end else begin
                  res_clear_ff <= 1'b0;
                  if (take_new) begin
                     next_id_ff    <= next_id_ff + 1'b1;
                     res_id_ff     <= FID_W'(next_id_ff);
                     res_status_ff <= 1'b0;
                  end else begin
                     res_id_ff     <= '0;
                     res_status_ff <= 1'b1;
                  end
                  state_ff <= S_OUT;
               end
            end
            S_SCAN_ID: begin
               id_ff <= fl_rd_ff;
               if (skip_id) begin
                  idx_ff   <= idx_nx[CNT_W-1:0];
                  state_ff <= S_SCAN_RD;
               end else begin
                  state_ff <= S_SCAN_CMP;
               end
            end
            S_SCAN_CMP: begin
               if (take_old) begin
                  res_id_ff     <= FID_W'(id_ff);
                  res_status_ff <= 1'b0;
                  res_clear_ff  <= 1'b1;
                  state_ff      <= S_SHIFT_RD;
               end else begin
                  idx_ff   <= idx_nx[CNT_W-1:0];
                  state_ff <= S_SCAN_RD;
               end
            end
            S_SHIFT_RD: begin
               if (idx_nx < {1'b0, free_cnt_ff}) begin
                  state_ff <= S_SHIFT_WR;
               end else begin
                  free_cnt_ff <= free_cnt_ff - 1'b1;
                  state_ff    <= S_OUT;
               end
            end
            S_SHIFT_WR: begin
               idx_ff   <= idx_nx[CNT_W-1:0];
               state_ff <= S_SHIFT_RD;
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_id_ff     <= res_id_ff;
                  rsp_status_ff <= res_status_ff;
                  rsp_clear_ff  <= res_clear_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_free_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      32'(free_cnt_ff) <= 32'(MAX_COUNTERS))
      else $error("free list count above capacity");

   a_hwm_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> next_id_ff >= $past(next_id_ff))
      else $error("high-water mark went down");

   a_free_cnt_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (free_cnt_ff == $past(free_cnt_ff))
         || (free_cnt_ff == $past(free_cnt_ff) + 1'b1)
         || (free_cnt_ff == $past(free_cnt_ff) - 1'b1))
      else $error("free list count jumped");

   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_status_ff && rsp_clear_ff))
      else $error("full status together with clear flag");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN_CMP) && take_old |=> (state_ff == S_SHIFT_RD) && !req_tready)
      else $error("list compaction not started after reuse");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_counter_id_allocator_reuse_delay.sv =====
module tb_counter_id_allocator_reuse_delay;
   timeunit 1ns;
   timeprecision 1ps;

   import cida_pkg::*;

   localparam int unsigned SLOT_COUNT   = 1024;
   // run-time limit for ~1500 items, many times over the worst case
   localparam int unsigned CYCLE_LIMIT  = 40_000_000;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned REQ_PAD_W    = REQ_DATA_W - NOW_W - TYPE_W - FID_W;

   localparam logic STATUS_FULL = 1'b1;

   localparam logic [NOW_W-1:0] NOW_MAX = '1;
   localparam logic [TMO_W-1:0] TMO_MAX = '1;

   typedef enum logic [1:0] {SLOT_UNUSED, SLOT_ALLOCATED, SLOT_RECLAIMED} slot_state_type;

   typedef struct packed {
      logic              mode;
      logic [NOW_W-1:0]  now_ms;
      logic [TYPE_W-1:0] type_code;
      logic [FID_W-1:0]  free_id;
   } counter_req_type;

   typedef struct packed {
      logic             clear_value;
      logic             status;
      logic [FID_W-1:0] granted_id;
   } grant_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   // predictor state
   logic [CAP_W-1:0] cfg_capacity = CAP_RESET;
   logic [TMO_W-1:0] cfg_timeout  = '0;
   logic [DL_W-1:0]  reuse_at [SLOT_COUNT];
   slot_state_type   slot_state [SLOT_COUNT] = '{default: SLOT_UNUSED};
   logic [FID_W-1:0] reclaim_fifo [$];
   int unsigned      high_water = 0;

   grant_type        expected_grants [$];
   logic [NOW_W-1:0] wall_ms = '0;
   int unsigned      error_count   = 0;
   int unsigned      checked_count = 0;
   int unsigned      cycle_count   = 0;
   int unsigned      send_idle_pct = 0;
   int unsigned      recv_idle_pct = 0;
   int unsigned      rx_hold_left  = 0;

   counter_id_allocator_reuse_delay #(
      .MAX_COUNTERS(SLOT_COUNT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (rx_hold_left != 0) begin
         rx_hold_left <= rx_hold_left - 1;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic void claim_slot(input logic [FID_W-1:0] id);
      slot_state[id] = SLOT_ALLOCATED;
      reuse_at[id]   = '1;
   endfunction

   function automatic grant_type predict_grant(input counter_req_type item);
      grant_type   g;
      int unsigned lim;
      g   = '0;
      lim = (cfg_capacity < SLOT_COUNT) ? cfg_capacity : SLOT_COUNT;
      if (item.mode == MODE_FREE) begin
         g.granted_id = item.free_id;
         if (slot_state[item.free_id] == SLOT_ALLOCATED && reclaim_fifo.size() < SLOT_COUNT) begin
            reuse_at[item.free_id]   = DL_W'(item.now_ms) + DL_W'(cfg_timeout);
            slot_state[item.free_id] = SLOT_RECLAIMED;
            reclaim_fifo.push_back(item.free_id);
         end
         return g;
      end
      for (int pos = 0; pos < reclaim_fifo.size(); pos++) begin
         if (reclaim_fifo[pos] >= lim) continue;
         if (DL_W'(item.now_ms) >= reuse_at[reclaim_fifo[pos]]) begin
            g.granted_id  = reclaim_fifo[pos];
            g.clear_value = 1'b1;
            reclaim_fifo.delete(pos);
            claim_slot(g.granted_id);
            return g;
         end
      end
      if (high_water < lim) begin
         g.granted_id = FID_W'(high_water);
         high_water++;
         claim_slot(g.granted_id);
         return g;
      end
      g.status = STATUS_FULL;
      return g;
   endfunction

   function automatic logic [FID_W-1:0] pick_live_id();
      logic [FID_W-1:0] live [$];
      for (int i = 0; i < SLOT_COUNT; i++)
         if (slot_state[i] == SLOT_ALLOCATED) live.push_back(FID_W'(i));
      if (live.size() == 0) return FID_W'($urandom);
      return live[$urandom_range(live.size() - 1)];
   endfunction

   function automatic counter_req_type make_request(input int unsigned alloc_pct);
      counter_req_type item;
      logic [63:0]     wide;
      int unsigned     roll;
      wide = {$urandom, $urandom};
      roll = $urandom_range(99);
      item.mode = ($urandom_range(99) < alloc_pct) ? MODE_ALLOC : MODE_FREE;
      if (roll < 3) begin
         item.now_ms = wide[NOW_W-1:0];
      end else if (roll < 4) begin
         item.now_ms = NOW_MAX;
      end else begin
         wall_ms     = wall_ms + NOW_W'($urandom_range(40));
         item.now_ms = wall_ms;
      end
      item.type_code = $urandom;
      if (item.mode == MODE_FREE && $urandom_range(99) < 85) item.free_id = pick_live_id();
      else item.free_id = FID_W'($urandom);
      return item;
   endfunction

   function automatic counter_req_type req_of(input logic mode, input logic [NOW_W-1:0] now_ms,
                                              input logic [TYPE_W-1:0] code,
                                              input logic [FID_W-1:0] fid);
      counter_req_type item;
      item.mode      = mode;
      item.now_ms    = now_ms;
      item.type_code = code;
      item.free_id   = fid;
      return item;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s at item %0d: got %0h, expected %0h",
               what, checked_count, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_grants.size() == 0) begin
            report_mismatch("item with nothing expected", rsp_tdata, 0);
         end else begin
            want = expected_grants.pop_front();
            if (rsp_tdata[FID_W-1:0] !== want.granted_id)
               report_mismatch("granted_id", rsp_tdata[FID_W-1:0], want.granted_id);
            if (rsp_tdata[FID_W] !== want.status)
               report_mismatch("status", rsp_tdata[FID_W], want.status);
            if (rsp_tdata[FID_W+1] !== want.clear_value)
               report_mismatch("clear_value", rsp_tdata[FID_W+1], want.clear_value);
         end
         checked_count++;
      end
   end

   task automatic send_item(input counter_req_type item, output grant_type predicted);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= item.mode;
      req_tdata  <= {{REQ_PAD_W{1'b0}}, item.free_id, item.type_code, item.now_ms};
      do @(posedge clock); while (!req_tready);
      predicted = predict_grant(item);
      expected_grants.push_back(predicted);
   endtask

   // only with the block idle: no item offered, none outstanding
   task automatic reconfigure(input int unsigned cap, input logic [TMO_W-1:0] tmo);
      req_tvalid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_CAPACITY;
      csr_data  <= CSR_DATA_W'(cap);
      do @(posedge clock); while (!csr_ready);
      cfg_capacity = CAP_W'(cap);
      csr_index <= CSR_TIMEOUT;
      csr_data  <= CSR_DATA_W'(tmo);
      do @(posedge clock); while (!csr_ready);
      cfg_timeout = tmo;
      csr_valid <= 1'b0;
   endtask

   task automatic run_traffic(input int unsigned count, input int unsigned alloc_pct);
      grant_type g;
      repeat (count) send_item(make_request(alloc_pct), g);
   endtask

   task automatic test_directed_cases();
      grant_type g;
      reconfigure(0, 0);
      send_item(req_of(MODE_ALLOC, 0, 0, 0), g);
      reconfigure(SLOT_COUNT, 0);
      send_item(req_of(MODE_ALLOC, 0, 32'h8000_0000, 0), g);
      send_item(req_of(MODE_ALLOC, 0, 32'h7FFF_FFFF, 0), g);
      send_item(req_of(MODE_ALLOC, 1, 32'hFFFF_FFFF, 10'h3FF), g);
      // free of ids never handed out
      send_item(req_of(MODE_FREE, 0, 0, 5), g);
      send_item(req_of(MODE_FREE, 0, 0, 10'h3FF), g);
      // double free
      send_item(req_of(MODE_FREE, 100, 0, 0), g);
      send_item(req_of(MODE_FREE, 100, 0, 0), g);
      // one ms early, then exactly at the deadline
      send_item(req_of(MODE_ALLOC, 99, 1, 0), g);
      send_item(req_of(MODE_ALLOC, 100, 2, 0), g);
      reconfigure(SLOT_COUNT, TMO_MAX);
      send_item(req_of(MODE_FREE, NOW_MAX, 0, 1), g);
      send_item(req_of(MODE_ALLOC, NOW_MAX, 3, 0), g);
      send_item(req_of(MODE_FREE, 0, 0, 2), g);
      send_item(req_of(MODE_ALLOC, NOW_W'(TMO_MAX) - 1, 4, 0), g);
      send_item(req_of(MODE_ALLOC, NOW_W'(TMO_MAX), 5, 0), g);
      reconfigure(SLOT_COUNT, 0);
      send_item(req_of(MODE_FREE, 0, 0, 3), g);
      // id 3 above the reduced capacity is skipped, mark is past it: full
      reconfigure(2, 0);
      send_item(req_of(MODE_ALLOC, 50, 6, 0), g);
      reconfigure(SLOT_COUNT, 0);
      send_item(req_of(MODE_FREE, 0, 0, 4), g);
      send_item(req_of(MODE_FREE, 0, 0, 5), g);
      send_item(req_of(MODE_ALLOC, 0, 7, 0), g);
      send_item(req_of(MODE_ALLOC, 0, 8, 0), g);
   endtask

   task automatic test_small_capacity_reuse();
      reconfigure($urandom_range(2, 16), $urandom_range(0, 20));
      run_traffic(80, 55);
      reconfigure($urandom_range(2, 16), $urandom_range(0, 20));
      run_traffic(70, 55);
   endtask

   task automatic test_high_water_growth();
      reconfigure(SLOT_COUNT, TMO_MAX);
      run_traffic(150, 80);
      reconfigure($urandom_range(40, 200), $urandom_range(0, 300));
      run_traffic(100, 50);
   endtask

   task automatic test_backpressure_stall();
      reconfigure(24, 5);
      rx_hold_left <= 400;
      run_traffic(60, 50);
   endtask

   task automatic test_fill_to_capacity();
      grant_type   g;
      int unsigned guard;
      reconfigure(SLOT_COUNT, 0);
      g     = '0;
      guard = 0;
      while (g.status != STATUS_FULL && guard < 2 * SLOT_COUNT + 8) begin
         send_item(make_request(100), g);
         guard++;
      end
      send_item(req_of(MODE_FREE, wall_ms, 0, 10'h3FF), g);
      run_traffic(40, 20);
      run_traffic(80, 60);
   endtask

   initial begin
      send_idle_pct = 12;
      recv_idle_pct = 68;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_small_capacity_reuse();
      send_idle_pct = 68;
      recv_idle_pct = 12;
      test_high_water_growth();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure_stall();
      test_fill_to_capacity();
      req_tvalid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
